@@ rtl/hsv2rgb_pkg.sv @@
// ---------------------------------------------------------------------------
// hsv2rgb_pkg
// Types and constants shared by the HSV to RGB converter files.
// ---------------------------------------------------------------------------
package hsv2rgb_pkg;

	localparam int HUE_W     = 9;
	localparam int Q_W       = 9;
	localparam int CH_W      = 8;
	localparam int T_W       = 6;
	localparam int IDX_W     = 2;

	localparam logic [HUE_W-1:0] HUE_MAX    = 9'd360;
	localparam logic [HUE_W-1:0] SECTOR_DEG = 9'd60;
	localparam logic [Q_W-1:0]   Q_ONE      = 9'd256;
	localparam logic [CH_W-1:0]  FULL_SCALE = 8'd255;

	// floor(q / 60) == (q * RECIP_60) >> RECIP_SHIFT for q below 23831
	localparam logic [14:0] RECIP_60    = 15'd17477;
	localparam int          RECIP_SHIFT = 20;

	// register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_SATURATION = 2'd0;
	localparam logic [IDX_W-1:0] REG_BRIGHTNESS = 2'd1;

	typedef enum logic [2:0] {
		SEC_RED_YELLOW     = 3'd0,
		SEC_YELLOW_GREEN   = 3'd1,
		SEC_GREEN_CYAN     = 3'd2,
		SEC_CYAN_BLUE      = 3'd3,
		SEC_BLUE_MAGENTA   = 3'd4,
		SEC_MAGENTA_RED    = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t          sector;
		logic [T_W-1:0]   t;          // secondary weight in sixtieths, 0..60
		logic             range_err;
	} sect_info_t;

endpackage

@@ rtl/hsv2rgb_sector.sv @@
// ---------------------------------------------------------------------------
// hsv2rgb_sector
// Splits a hue into its 60-degree sector and the secondary weight t/60.
// ---------------------------------------------------------------------------
module hsv2rgb_sector (
	input  logic [hsv2rgb_pkg::HUE_W-1:0] hue,
	output hsv2rgb_pkg::sect_info_t       info
);
	import hsv2rgb_pkg::*;

	logic [HUE_W-1:0] h;
	logic [HUE_W-1:0] base;
	logic [HUE_W-1:0] frac;
	sector_t          sec;

	always_comb begin
		// 360 wraps to sector 0
		h = (hue == HUE_MAX) ? '0 : hue;
		if (h >= 9'd300) begin
			sec  = SEC_MAGENTA_RED;
			base = 9'd300;
		end else if (h >= 9'd240) begin
			sec  = SEC_BLUE_MAGENTA;
			base = 9'd240;
		end else if (h >= 9'd180) begin
			sec  = SEC_CYAN_BLUE;
			base = 9'd180;
		end else if (h >= 9'd120) begin
			sec  = SEC_GREEN_CYAN;
			base = 9'd120;
		end else if (h >= SECTOR_DEG) begin
			sec  = SEC_YELLOW_GREEN;
			base = SECTOR_DEG;
		end else begin
			sec  = SEC_RED_YELLOW;
			base = '0;
		end
		frac = h - base;
		info.sector    = sec;
		// odd sectors fall from 1 to 0 across the sector
		info.t         = sec[0] ? T_W'(SECTOR_DEG - frac) : frac[T_W-1:0];
		info.range_err = (hue > HUE_MAX);
	end

endmodule

@@ rtl/hsv_to_rgb_converter_top.sv @@
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// HSV to RGB converter: one hue in, one 8-bit RGB triple out.
// ---------------------------------------------------------------------------
// Takes one hue per clock and returns one RGB item per clock while the
// result side is not blocked; each item passes five register stages
// (sector split, two multiply stages, rounding, then the divide by sixty
// done as a reciprocal multiply), and a result is offered from the fifth
// stage register. Each stage holds its own item while the next is blocked,
// so backpressure on the result side stalls only as far back as the
// pipeline is full. Saturation and brightness are Q1.8 (256 is 1.0); values
// above 256 are used as 256. A hue above 360 gives black with range_error
// set on tuser.
module hsv_to_rgb_converter_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [8:0]  cfg_data,
	// hue in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [8:0] hue, rest zero
	// colour out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // [7:0] red, [15:8] green, [23:16] blue
	output logic        m_tuser     // [0] range_error
);
	import hsv2rgb_pkg::*;

	logic [Q_W-1:0] sat_q, bri_q;
	logic [Q_W-1:0] sat_c, bri_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= Q_ONE;
			bri_q <= 9'd128;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SATURATION: sat_q <= cfg_data;
				REG_BRIGHTNESS: bri_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sat_c = (sat_q > Q_ONE) ? Q_ONE : sat_q;
	assign bri_c = (bri_q > Q_ONE) ? Q_ONE : bri_q;

	// stage enables: a stage loads when empty or when its successor moves
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en1, en2, en3, en4, en5;

	assign en5      = !vld_s5 || m_tready;
	assign en4      = !vld_s4 || en5;
	assign en3      = !vld_s3 || en4;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= s_tvalid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	// ---- stage 1: sector split --------------------------------------------
	sect_info_t     info;
	sect_info_t     info_s1;
	logic [Q_W-1:0] sat_s1, bri_s1;

	hsv2rgb_sector u_sector (
		.hue  (s_tdata[HUE_W-1:0]),
		.info (info)
	);

	always_ff @(posedge clk) begin
		if (en1) begin
			info_s1 <= info;
			sat_s1  <= sat_c;
			bri_s1  <= bri_c;
		end
	end

	// ---- stage 2: u = s*t + 60*(1-s), vz = v*(1-s) ------------------------
	logic [Q_W-1:0] inv_s;
	logic [14:0]    u_sum;
	sect_info_t     info_s2;
	logic [13:0]    u_s2;
	logic [16:0]    vz_s2;
	logic [Q_W-1:0] bri_s2;

	assign inv_s = Q_ONE - sat_s1;
	assign u_sum = 15'(sat_s1 * info_s1.t) + 15'(inv_s * SECTOR_DEG);

	always_ff @(posedge clk) begin
		if (en2) begin
			info_s2 <= info_s1;
			u_s2    <= u_sum[13:0];
			vz_s2   <= 17'(bri_s1 * inv_s);
			bri_s2  <= bri_s1;
		end
	end

	// ---- stage 3: w = v*u; chroma and zero channels finish here -----------
	logic [24:0]     z_full;
	logic [16:0]     c_full;
	sect_info_t      info_s3;
	logic [21:0]     w_s3;
	logic [CH_W-1:0] zch_s3, cch_s3;

	// zero channel: round(255*v*(1-s) / 65536)
	assign z_full = 25'(vz_s2 * FULL_SCALE) + 25'd32768;
	// chroma channel: C + m == v, so round(255*v / 256)
	assign c_full = 17'(bri_s2 * FULL_SCALE) + 17'd128;

	always_ff @(posedge clk) begin
		if (en3) begin
			info_s3 <= info_s2;
			w_s3    <= 22'(bri_s2 * u_s2);
			zch_s3  <= z_full[23:16];
			cch_s3  <= c_full[15:8];
		end
	end

	// ---- stage 4: scale by 255, add half, drop 16 bits ---------------------
	logic [30:0]     w_full;
	sect_info_t      info_s4;
	logic [13:0]     q_s4;
	logic [CH_W-1:0] zch_s4, cch_s4;

	assign w_full = 31'(w_s3 * FULL_SCALE) + 31'd1966080;

	always_ff @(posedge clk) begin
		if (en4) begin
			info_s4 <= info_s3;
			q_s4    <= w_full[29:16];
			zch_s4  <= zch_s3;
			cch_s4  <= cch_s3;
		end
	end

	// ---- stage 5: divide by 60, place components by sector -----------------
	logic [28:0]     x_prod;
	logic [CH_W-1:0] xch;
	logic [CH_W-1:0] r_n, g_n, b_n;
	logic [CH_W-1:0] red_s5, green_s5, blue_s5;
	logic            rerr_s5;

	assign x_prod = 29'(q_s4 * RECIP_60);
	assign xch    = x_prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];

	always_comb begin
		case (info_s4.sector)
			SEC_RED_YELLOW: begin
				r_n = cch_s4; g_n = xch;    b_n = zch_s4;
			end
			SEC_YELLOW_GREEN: begin
				r_n = xch;    g_n = cch_s4; b_n = zch_s4;
			end
			SEC_GREEN_CYAN: begin
				r_n = zch_s4; g_n = cch_s4; b_n = xch;
			end
			SEC_CYAN_BLUE: begin
				r_n = zch_s4; g_n = xch;    b_n = cch_s4;
			end
			SEC_BLUE_MAGENTA: begin
				r_n = xch;    g_n = zch_s4; b_n = cch_s4;
			end
			default: begin
				r_n = cch_s4; g_n = zch_s4; b_n = xch;
			end
		endcase
		if (info_s4.range_err) begin
			r_n = '0;
			g_n = '0;
			b_n = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			red_s5   <= r_n;
			green_s5 <= g_n;
			blue_s5  <= b_n;
			rerr_s5  <= info_s4.range_err;
		end
	end

	assign m_tvalid = vld_s5;
	assign m_tdata  = {blue_s5, green_s5, red_s5};
	assign m_tuser  = rerr_s5;

endmodule

@@ dv/hsv_to_rgb_converter_top_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter_top_tb
// Self-checking bench for the HSV to RGB converter.
// Hues stream in with random gaps and colours drain under random
// backpressure. Each colour is checked field by field against an in-bench
// predictor, over a run of saturation and brightness settings.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter_top_tb;
	import hsv2rgb_pkg::*;

	localparam int               HALF_PERIOD    = 5;
	localparam int               RANDOM_PHASES  = 11;
	localparam int               HUES_PER_PHASE = 105;
	localparam int               DRAIN_CYCLES   = 12;
	localparam int               WATCHDOG_LIMIT = 1000;
	localparam int               MAX_WAIT       = 19;
	localparam longint unsigned  CH_DENOM       = 64'd65536 * 64'd60;
	localparam logic [IDX_W-1:0] REG_SPARE_2    = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_3    = 2'd3;

	// sector edges, wrap point, out-of-range and bit patterns
	localparam logic [HUE_W-1:0] CORNER_HUES [17] = '{
		9'd0, 9'd1, 9'd30, 9'd59, 9'd60, 9'd61, 9'd120, 9'd180, 9'd240,
		9'd300, 9'd359, 9'd360, 9'd361, 9'd511, 9'd256, 9'd255, 9'd170
	};

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            range_error;
	} colour_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        cfg_we   = 1'b0;
	logic [1:0]  cfg_idx  = '0;
	logic [8:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;    // [8:0] hue
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;          // [7:0] red, [15:8] green, [23:16] blue
	logic        m_tuser;          // [0] range_error

	logic [Q_W-1:0]   cur_saturation = Q_ONE;
	logic [Q_W-1:0]   cur_brightness = 9'd128;
	logic [HUE_W-1:0] pending_hues [$];
	colour_t          expected_colours [$];
	colour_t          got_colour;
	colour_t          want_colour;
	int               hues_queued  = 0;
	int               hues_taken   = 0;
	int               send_wait    = 0;
	int               recv_wait    = 0;
	bit               send_burst   = 1'b0;
	bit               recv_burst   = 1'b0;
	int               quiet_cycles = 0;
	int               mismatches   = 0;

	hsv_to_rgb_converter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #HALF_PERIOD clk = ~clk;

	// (num / 65536 / 60) * 255, rounded half up
	function automatic logic [CH_W-1:0] to_intensity(longint unsigned num);
		longint unsigned level;
		level = (num * FULL_SCALE + CH_DENOM / 2) / CH_DENOM;
		return (level > FULL_SCALE) ? FULL_SCALE : level[CH_W-1:0];
	endfunction

	function automatic colour_t predict_colour(logic [HUE_W-1:0] hue);
		colour_t         c;
		longint unsigned sat, val, deg, frac, weight;
		longint unsigned chroma, second, offset, rn, gn, bn;
		sector_t         sec;
		c = '0;
		if (hue > HUE_MAX) begin
			c.range_error = 1'b1;
			return c;
		end
		sat    = 64'((cur_saturation > Q_ONE) ? Q_ONE : cur_saturation);
		val    = 64'((cur_brightness > Q_ONE) ? Q_ONE : cur_brightness);
		deg    = (hue == HUE_MAX) ? 64'd0 : 64'(hue);
		sec    = sector_t'(deg / SECTOR_DEG);
		frac   = deg % SECTOR_DEG;
		// odd sectors fall, even ones rise
		weight = ((deg / SECTOR_DEG) % 2 == 1) ? SECTOR_DEG - frac : frac;
		chroma = val * sat * SECTOR_DEG;
		second = val * sat * weight;
		offset = val * (Q_ONE - sat) * SECTOR_DEG;
		case (sec)
			SEC_RED_YELLOW: begin
				rn = chroma; gn = second; bn = 0;
			end
			SEC_YELLOW_GREEN: begin
				rn = second; gn = chroma; bn = 0;
			end
			SEC_GREEN_CYAN: begin
				rn = 0; gn = chroma; bn = second;
			end
			SEC_CYAN_BLUE: begin
				rn = 0; gn = second; bn = chroma;
			end
			SEC_BLUE_MAGENTA: begin
				rn = second; gn = 0; bn = chroma;
			end
			default: begin
				rn = chroma; gn = 0; bn = second;
			end
		endcase
		c.red   = to_intensity(rn + offset);
		c.green = to_intensity(gn + offset);
		c.blue  = to_intensity(bn + offset);
		return c;
	endfunction

	// hue driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_colours.insert(expected_colours.size(),
					predict_colour(s_tdata[HUE_W-1:0]));
				hues_taken++;
				if ($urandom_range(0, 31) == 0) begin
					send_burst = !send_burst;
				end
				send_wait = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
			end
			// an offered item stays put until taken
			if (!s_tvalid || s_tready) begin
				if (send_wait > 0) begin
					send_wait--;
					s_tvalid <= 1'b0;
				end else if (pending_hues.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {7'd0, pending_hues.pop_front()};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// colour monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_colour = '{red: m_tdata[7:0], green: m_tdata[15:8],
					blue: m_tdata[23:16], range_error: m_tuser};
				if (expected_colours.size() == 0) begin
					$error("colour item with no hue waiting: tdata %h tuser %b",
						m_tdata, m_tuser);
					mismatches++;
				end else begin
					want_colour = expected_colours.pop_front();
					if (got_colour.red !== want_colour.red) begin
						$error("red: expected %0d, actual %0d", want_colour.red, got_colour.red);
						mismatches++;
					end
					if (got_colour.green !== want_colour.green) begin
						$error("green: expected %0d, actual %0d",
							want_colour.green, got_colour.green);
						mismatches++;
					end
					if (got_colour.blue !== want_colour.blue) begin
						$error("blue: expected %0d, actual %0d", want_colour.blue, got_colour.blue);
						mismatches++;
					end
					if (got_colour.range_error !== want_colour.range_error) begin
						$error("range_error: expected %0b, actual %0b",
							want_colour.range_error, got_colour.range_error);
						mismatches++;
					end
				end
				if ($urandom_range(0, 31) == 0) begin
					recv_burst = !recv_burst;
				end
				recv_wait = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	task automatic write_register(logic [IDX_W-1:0] idx, logic [Q_W-1:0] value);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SATURATION) begin
			cur_saturation = value;
		end else if (idx == REG_BRIGHTNESS) begin
			cur_brightness = value;
		end
	endtask

	// unmapped indexes get junk first; it must not disturb the real settings
	task automatic set_colour_mode(logic [Q_W-1:0] sat, logic [Q_W-1:0] bright);
		write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
			Q_W'($urandom_range(0, 511)));
		write_register(REG_SATURATION, sat);
		write_register(REG_BRIGHTNESS, bright);
	endtask

	task automatic queue_hue(logic [HUE_W-1:0] hue);
		pending_hues.insert(pending_hues.size(), hue);
		hues_queued++;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (hues_taken != hues_queued || expected_colours.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [Q_W-1:0] sat;
		logic [Q_W-1:0] bright;
		int             pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: full saturation, half brightness
		@(negedge clk);
		foreach (CORNER_HUES[i]) begin
			queue_hue(CORNER_HUES[i]);
		end
		wait_idle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					sat = 9'd0; bright = 9'd0;
				end
				1: begin
					sat = 9'd256; bright = 9'd256;
				end
				2: begin
					sat = 9'd0; bright = 9'd256;
				end
				3: begin
					sat = 9'd256; bright = 9'd0;
				end
				4: begin
					sat = 9'd511; bright = 9'd511;
				end
				5: begin
					sat = 9'd257; bright = 9'd1;
				end
				default: begin
					sat    = Q_W'(($urandom_range(0, 3) == 0) ? $urandom_range(257, 511)
						: $urandom_range(0, 256));
					bright = Q_W'(($urandom_range(0, 3) == 0) ? $urandom_range(257, 511)
						: $urandom_range(0, 256));
				end
			endcase
			set_colour_mode(sat, bright);
			@(negedge clk);
			repeat (HUES_PER_PHASE) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					queue_hue(HUE_W'($urandom_range(HUE_MAX + 1, 511)));
				end else if (pick < 16) begin
					queue_hue(CORNER_HUES[$urandom_range(0, $size(CORNER_HUES) - 1)]);
				end else begin
					queue_hue(HUE_W'($urandom_range(0, HUE_MAX)));
				end
			end
			wait_idle();
		end

		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
